// ----- hw/rtl/c3r_pkg.sv -----
// shared types and constants of the 3x3 reflect-border convolution
// used by c3r_linebuf, c3r_tap_cell, conv3x3_reflect_clamp and c3r_checker
package c3r_pkg;

	localparam int PIX_W   = 8;
	localparam int COEF_W  = 16;
	localparam int KSIZE   = 3;
	localparam int PROD_W  = PIX_W + 1 + COEF_W;
	localparam int SUM_W   = PROD_W + 4;
	localparam int PIX_MAX = 255;

	// register file layout
	localparam int WREG_W = 13;
	localparam int HREG_W = 16;
	localparam int KREG_W = 48;
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_WIDTH  = 3'd0;
	localparam reg_idx_t REG_HEIGHT = 3'd1;
	localparam reg_idx_t REG_KTOP   = 3'd2;
	localparam reg_idx_t REG_KMID   = 3'd3;
	localparam reg_idx_t REG_KBOT   = 3'd4;

	localparam logic [WREG_W-1:0] WIDTH_RST  = 13'd512;
	localparam logic [HREG_W-1:0] HEIGHT_RST = 16'd512;
	localparam logic [KREG_W-1:0] KMID_RST   = 48'h0000_0100_0000;

	typedef logic [PIX_W-1:0] pix_t;

	// one window column, index is the kernel row
	typedef pix_t [KSIZE-1:0] col_t;

	// one result travelling down the tap chain
	typedef struct packed {
		logic                  valid;
		logic                  lor;
		logic                  eof;
		col_t [KSIZE-1:0]      cols;
		logic [SUM_W-1:0]      sum;
	} tap_t;

endpackage

// ----- hw/rtl/c3r_linebuf.sv -----
// two row stores of the convolution window, one read and one write port each
// depends on c3r_pkg
module c3r_linebuf #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  c3r_pkg::pix_t       wr_pix,
	output c3r_pkg::pix_t       upper_q,
	output c3r_pkg::pix_t       lower_q
);

	c3r_pkg::pix_t upper_mem [DEPTH];
	c3r_pkg::pix_t lower_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			upper_q <= upper_mem[rd_addr];
			lower_q <= lower_mem[rd_addr];
		end
	end

	// the row one back moves up, the new pixel takes its place
	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr] <= lower_q;
			lower_mem[wr_addr] <= wr_pix;
		end
	end

endmodule

// ----- hw/rtl/c3r_tap_cell.sv -----
// one kernel column of the multiply-accumulate chain
// depends on c3r_pkg
module c3r_tap_cell (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  logic [c3r_pkg::KSIZE-1:0][c3r_pkg::COEF_W-1:0] coef,
	input  c3r_pkg::tap_t                                 tap_in,
	output c3r_pkg::tap_t                                 tap_out
);

	logic                                           valid_s1;
	logic                                           valid_s2;
	c3r_pkg::tap_t                                  pass_s1;
	c3r_pkg::tap_t                                  pass_s2;
	c3r_pkg::tap_t                                  shifted;
	c3r_pkg::tap_t                                  summed;
	logic [c3r_pkg::KSIZE-1:0][c3r_pkg::PROD_W-1:0] prod_s1;
	logic signed [c3r_pkg::SUM_W-1:0]               acc;

	// hand the remaining columns on, next cell sees its own at index 0
	always_comb begin
		shifted = tap_in;
		for (int k = 0; k < c3r_pkg::KSIZE - 1; k++) begin
			shifted.cols[k] = tap_in.cols[k+1];
		end
		shifted.cols[c3r_pkg::KSIZE-1] = '0;
	end

	always_comb begin
		acc = $signed(pass_s1.sum);
		for (int i = 0; i < c3r_pkg::KSIZE; i++) begin
			acc = acc + c3r_pkg::SUM_W'($signed(prod_s1[i]));
		end
		summed     = pass_s1;
		summed.sum = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= tap_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_s1 <= shifted;
			for (int i = 0; i < c3r_pkg::KSIZE; i++) begin
				prod_s1[i] <= c3r_pkg::PROD_W'($signed({1'b0, tap_in.cols[0][i]}))
					* c3r_pkg::PROD_W'($signed(coef[i]));
			end
			pass_s2 <= summed;
		end
	end

	always_comb begin
		tap_out       = pass_s2;
		tap_out.valid = valid_s2;
	end

endmodule

// ----- hw/rtl/conv3x3_reflect_clamp.sv -----
// top level of the streaming 3x3 convolution with reflect-101 borders
// depends on c3r_pkg, c3r_linebuf and c3r_tap_cell

// Gray pixels come in raster order, one per transfer, and are filtered with a
// 3x3 kernel of signed Q8.8 coefficients; borders mirror without repeating the
// edge pixel, and each sum is truncated toward zero and clamped to 0..255.
// Results lag one row and one column. A row takes one pixel per clock while the
// output does not stall: the input also stalls on the last pixel of a row and
// on every pixel of the last row, since each extra result leaves through the
// single output register. That rate is set by the issue stage, which, unless
// the output stalls, starts one result a clock into a chain of three tap cells
// (one per kernel column, a multiply stage and an add stage each). Two row
// stores of MAX_WIDTH bytes each hold the previous two rows; they are not
// cleared and need no clearing pass. Registers lie at byte address 8*i of a
// 64-bit port: width, height, kernel top, middle and bottom row, each row three
// 16-bit coefficients with the left one in bits 15:0. Write them only while no
// pixel is in flight.
module conv3x3_reflect_clamp #(
	parameter int MAX_WIDTH      = 4096,
	parameter int COEF_FRAC_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [c3r_pkg::ADDR_W-1:0]   paddr,
	input  logic [c3r_pkg::DATA_W-1:0]   pwdata,
	output logic [c3r_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	// pixel input
	input  logic                         pixel_valid,
	output logic                         pixel_stall,
	input  logic [c3r_pkg::PIX_W-1:0]    pixel_in,
	// results
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [c3r_pkg::PIX_W-1:0]    pixel_out,
	output logic                         last_of_run,
	output logic                         end_of_frame
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CNT_W = $clog2(MAX_WIDTH + 1);
	localparam int WID_W = (CNT_W > c3r_pkg::WREG_W) ? CNT_W : c3r_pkg::WREG_W;
	localparam int ROW_W = c3r_pkg::HREG_W;

	// result kinds of one pixel, in output order
	localparam int K_PLAIN    = 0;	// previous row, column c-1
	localparam int K_PLAIN_MR = 1;	// last row mirrored, column c-1
	localparam int K_EDGE     = 2;	// previous row, last column
	localparam int K_EDGE_MR  = 3;	// last row mirrored, last column
	localparam int NKIND      = 4;

	typedef struct packed {
		logic r_ge1;
		logic r_is1;
		logic c_ge1;
		logic c_is1;
		logic last_col;
		logic last_row;
	} pos_t;

	function automatic c3r_pkg::col_t mirror_col(input c3r_pkg::col_t c, input logic mir);
		c3r_pkg::col_t m;
		m = c;
		if (mir) begin
			// last row mirrored about itself: rows are (mid, bottom, mid)
			m[0] = c[1];
			m[1] = c[2];
			m[2] = c[1];
		end
		return m;
	endfunction

	// ---------------------------------------------------------------- registers
	logic                           cfg_wr;
	c3r_pkg::reg_idx_t              cfg_idx;
	logic [c3r_pkg::WREG_W-1:0]     width_q;
	logic [c3r_pkg::HREG_W-1:0]     height_q;
	logic [c3r_pkg::KREG_W-1:0]     krn_q [c3r_pkg::KSIZE];

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[c3r_pkg::ADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= c3r_pkg::WIDTH_RST;
			height_q <= c3r_pkg::HEIGHT_RST;
			krn_q[0] <= '0;
			krn_q[1] <= c3r_pkg::KMID_RST;
			krn_q[2] <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				c3r_pkg::REG_WIDTH:  width_q  <= pwdata[c3r_pkg::WREG_W-1:0];
				c3r_pkg::REG_HEIGHT: height_q <= pwdata[c3r_pkg::HREG_W-1:0];
				c3r_pkg::REG_KTOP:   krn_q[0] <= pwdata[c3r_pkg::KREG_W-1:0];
				c3r_pkg::REG_KMID:   krn_q[1] <= pwdata[c3r_pkg::KREG_W-1:0];
				c3r_pkg::REG_KBOT:   krn_q[2] <= pwdata[c3r_pkg::KREG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			c3r_pkg::REG_WIDTH:  prdata = c3r_pkg::DATA_W'(width_q);
			c3r_pkg::REG_HEIGHT: prdata = c3r_pkg::DATA_W'(height_q);
			c3r_pkg::REG_KTOP:   prdata = c3r_pkg::DATA_W'(krn_q[0]);
			c3r_pkg::REG_KMID:   prdata = c3r_pkg::DATA_W'(krn_q[1]);
			c3r_pkg::REG_KBOT:   prdata = c3r_pkg::DATA_W'(krn_q[2]);
			default:             prdata = '0;
		endcase
	end

	// frame bounds as the counters see them: width 2..MAX_WIDTH, height at least 2
	logic [WID_W-1:0] w_eff;
	logic [ROW_W-1:0] h_eff;

	always_comb begin
		if (width_q < c3r_pkg::WREG_W'(2)) begin
			w_eff = WID_W'(2);
		end else if (WID_W'(width_q) > WID_W'(MAX_WIDTH)) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else begin
			w_eff = WID_W'(width_q);
		end
		h_eff = (height_q < ROW_W'(2)) ? ROW_W'(2) : height_q;
	end

	// ---------------------------------------------------------------- input side
	logic               en;
	logic               accept;
	logic               s1_adv;
	logic               s2_done;
	logic               valid_s1;
	logic               valid_s2;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [WID_W-1:0]   col_inc;
	logic [ROW_W:0]     row_inc;
	pos_t               pos_now;
	pos_t               pos_s1;
	c3r_pkg::pix_t      px_s1;
	logic [COL_W-1:0]   col_s1;

	assign accept      = pixel_valid & ~pixel_stall;
	assign s1_adv      = valid_s1 & (~valid_s2 | s2_done);
	assign pixel_stall = valid_s1 & ~s1_adv;

	always_comb begin
		col_inc          = WID_W'(col_q) + WID_W'(1);
		row_inc          = (ROW_W + 1)'(row_q) + (ROW_W + 1)'(1);
		pos_now.r_ge1    = (row_q != '0);
		pos_now.r_is1    = (row_q == ROW_W'(1));
		pos_now.c_ge1    = (col_q != '0);
		pos_now.c_is1    = (col_q == COL_W'(1));
		// a counter at or past a bound that shrank also counts as last
		pos_now.last_col = (col_inc >= w_eff);
		pos_now.last_row = (row_inc >= (ROW_W + 1)'(h_eff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (pos_now.last_col) begin
					col_q <= '0;
					row_q <= pos_now.last_row ? '0 : row_inc[ROW_W-1:0];
				end else begin
					col_q <= col_inc[COL_W-1:0];
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1  <= pixel_in;
			col_s1 <= col_q;
			pos_s1 <= pos_now;
		end
	end

	// row stores, read at transfer and written back when the pixel leaves stage 1
	c3r_pkg::pix_t upper_rd;
	c3r_pkg::pix_t lower_rd;

	c3r_linebuf #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W)
	) u_linebuf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_pix  (px_s1),
		.upper_q (upper_rd),
		.lower_q (lower_rd)
	);

	// ---------------------------------------------------------------- window and issue
	c3r_pkg::col_t      new_col;
	c3r_pkg::col_t      win_q [c3r_pkg::KSIZE];
	logic [NKIND-1:0]   mask_in;
	logic [NKIND-1:0]   mask_s2;
	logic [NKIND-1:0]   pick;
	logic [NKIND-1:0]   mask_rest;
	logic               c1_s2;
	logic               is_edge;
	logic               is_mir;
	c3r_pkg::col_t      sel_l;
	c3r_pkg::col_t      sel_m;
	c3r_pkg::col_t      sel_r;
	c3r_pkg::tap_t      iss_next;
	c3r_pkg::tap_t      iss_s3;
	c3r_pkg::tap_t      iss_tap;
	logic               iss_valid_s3;

	always_comb begin
		// on the second row the missing upper neighbor is the row below
		new_col[0] = pos_s1.r_is1 ? px_s1 : upper_rd;
		new_col[1] = lower_rd;
		new_col[2] = px_s1;

		mask_in             = '0;
		mask_in[K_PLAIN]    = pos_s1.r_ge1 & pos_s1.c_ge1;
		mask_in[K_PLAIN_MR] = pos_s1.r_ge1 & pos_s1.c_ge1 & pos_s1.last_row;
		mask_in[K_EDGE]     = pos_s1.r_ge1 & pos_s1.last_col;
		mask_in[K_EDGE_MR]  = pos_s1.r_ge1 & pos_s1.last_col & pos_s1.last_row;
	end

	always_comb begin
		pick      = mask_s2 & (~mask_s2 + NKIND'(1));
		mask_rest = mask_s2 & ~pick;
		is_edge   = pick[K_EDGE] | pick[K_EDGE_MR];
		is_mir    = pick[K_PLAIN_MR] | pick[K_EDGE_MR];
		if (is_edge) begin
			// last column: its right neighbor is the column to its left
			sel_l = win_q[1];
			sel_m = win_q[2];
			sel_r = win_q[1];
		end else begin
			// second column of a row: left neighbor mirrored from the right
			sel_l = c1_s2 ? win_q[2] : win_q[0];
			sel_m = win_q[1];
			sel_r = win_q[2];
		end
		iss_next         = '0;
		iss_next.valid   = valid_s2;
		iss_next.lor     = (mask_rest == '0);
		iss_next.eof     = pick[K_EDGE_MR];
		iss_next.cols[0] = mirror_col(sel_l, is_mir);
		iss_next.cols[1] = mirror_col(sel_m, is_mir);
		iss_next.cols[2] = mirror_col(sel_r, is_mir);
	end

	assign s2_done = valid_s2 & en & (mask_rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < c3r_pkg::KSIZE; k++) begin
				win_q[k] <= '0;
			end
			valid_s2     <= 1'b0;
			mask_s2      <= '0;
			c1_s2        <= 1'b0;
			iss_valid_s3 <= 1'b0;
		end else begin
			if (s1_adv) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= new_col;
				mask_s2  <= mask_in;
				c1_s2    <= pos_s1.c_is1;
				valid_s2 <= (mask_in != '0);
			end else if (valid_s2 && en) begin
				mask_s2  <= mask_rest;
				valid_s2 <= (mask_rest != '0);
			end
			if (en) begin
				iss_valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			iss_s3 <= iss_next;
		end
	end

	always_comb begin
		iss_tap       = iss_s3;
		iss_tap.valid = iss_valid_s3;
	end

	// ---------------------------------------------------------------- tap chain
	c3r_pkg::tap_t tap [c3r_pkg::KSIZE+1];
	logic [c3r_pkg::KSIZE-1:0][c3r_pkg::COEF_W-1:0] cell_coef [c3r_pkg::KSIZE];

	assign tap[0] = iss_tap;

	always_comb begin
		for (int j = 0; j < c3r_pkg::KSIZE; j++) begin
			for (int i = 0; i < c3r_pkg::KSIZE; i++) begin
				cell_coef[j][i] = krn_q[i][j*c3r_pkg::COEF_W +: c3r_pkg::COEF_W];
			end
		end
	end

	for (genvar j = 0; j < c3r_pkg::KSIZE; j++) begin : g_cell
		c3r_tap_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.coef    (cell_coef[j]),
			.tap_in  (tap[j]),
			.tap_out (tap[j+1])
		);
	end

	// ---------------------------------------------------------------- clamp and output
	logic [c3r_pkg::SUM_W-1:0]  fin_sum;
	logic [c3r_pkg::SUM_W-1:0]  fin_shift;
	c3r_pkg::pix_t              fin_pix;
	logic                       out_valid_q;
	c3r_pkg::pix_t              pix_q;
	logic                       lor_q;
	logic                       eof_q;

	// whole pipeline moves together unless a result waits on a stalled output
	assign en = ~out_valid_q | ~result_stall;

	always_comb begin
		fin_sum   = tap[c3r_pkg::KSIZE].sum;
		fin_shift = fin_sum >> COEF_FRAC_BITS;
		if (fin_sum[c3r_pkg::SUM_W-1] || fin_sum == '0) begin
			fin_pix = '0;
		end else if (fin_shift > c3r_pkg::SUM_W'(c3r_pkg::PIX_MAX)) begin
			fin_pix = c3r_pkg::PIX_W'(c3r_pkg::PIX_MAX);
		end else begin
			fin_pix = fin_shift[c3r_pkg::PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= tap[c3r_pkg::KSIZE].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && tap[c3r_pkg::KSIZE].valid) begin
			pix_q <= fin_pix;
			lor_q <= tap[c3r_pkg::KSIZE].lor;
			eof_q <= tap[c3r_pkg::KSIZE].eof;
		end
	end

	assign result_valid = out_valid_q;
	assign pixel_out    = pix_q;
	assign last_of_run  = lor_q;
	assign end_of_frame = eof_q;

endmodule

// ----- hw/rtl/c3r_checker.sv -----
// port-level checks of conv3x3_reflect_clamp, attached by bind
// depends on c3r_pkg
module c3r_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [c3r_pkg::ADDR_W-1:0]   paddr,
	input logic [c3r_pkg::DATA_W-1:0]   pwdata,
	input logic [c3r_pkg::DATA_W-1:0]   prdata,
	input logic                         pready,
	input logic                         pixel_valid,
	input logic                         pixel_stall,
	input logic [c3r_pkg::PIX_W-1:0]    pixel_in,
	input logic                         result_valid,
	input logic                         result_stall,
	input logic [c3r_pkg::PIX_W-1:0]    pixel_out,
	input logic                         last_of_run,
	input logic                         end_of_frame
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(pixel_out)
			&& $stable(last_of_run) && $stable(end_of_frame))
		else $error("result changed while stalled");

	// results of one pixel leave without gaps
	a_run_packed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !last_of_run |=> result_valid)
		else $error("gap inside a run of results");

	// the frame ends on the last result of a pixel
	a_eof_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && end_of_frame |-> last_of_run)
		else $error("end of frame without last of run");

	// out of reset the block is empty and takes pixels
	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !result_valid && !pixel_stall)
		else $error("block not idle after reset");

endmodule

bind conv3x3_reflect_clamp c3r_checker u_c3r_checker (.*);

// ----- test/testbench.sv -----
// self-checking testbench for the streaming 3x3 reflect-border convolution
// depends on c3r_pkg and conv3x3_reflect_clamp; a built-in predictor checks every result
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import c3r_pkg::*;

	localparam int LINE_MAX       = 4096;
	localparam int FRAC_BITS      = 8;
	// clocks to let the pipeline drain before a register write
	localparam int SETTLE_CYCLES  = 30;
	// no transfer at all for this long means the block hung
	localparam int QUIET_LIMIT    = 4000;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int RANDOM_PIXELS  = 170;

	// one filtered pixel as it should leave the block
	typedef struct packed {
		pix_t value;
		logic last_run;
		logic frame_end;
	} filtered_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                pixel_valid;
	logic                pixel_stall;
	pix_t                pixel_in;
	logic                result_valid;
	logic                result_stall;
	pix_t                pixel_out;
	logic                last_of_run;
	logic                end_of_frame;

	// predictor copy of the registers and of the filter state
	logic [WREG_W-1:0]   cfg_width;
	logic [HREG_W-1:0]   cfg_height;
	logic [KREG_W-1:0]   kernel_rows [KSIZE];
	pix_t                upper_row [LINE_MAX];
	pix_t                lower_row [LINE_MAX];
	col_t                window [KSIZE];
	logic [11:0]         col_pos;
	logic [15:0]         row_pos;
	filtered_t           queued_outputs [$];

	// sender and receiver pacing
	int                  burst_left;
	bit                  steady_sender;
	int                  hold_request;
	int                  hold_left;
	int                  stall_mode;
	int                  mode_left;
	logic [7:0]          stall_pattern;

	// bookkeeping
	int                  errors;
	int                  pixels_sent;
	int                  results_checked;
	int                  frames_checked;
	int                  reg_writes;
	int                  quiet_cycles;

	conv3x3_reflect_clamp #(
		.MAX_WIDTH      (LINE_MAX),
		.COEF_FRAC_BITS (FRAC_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_in     (pixel_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pixel_out    (pixel_out),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame)
	);

	always #6 clk = ~clk;

	// pack three signed coefficients, left one in the low bits
	function automatic logic [KREG_W-1:0] kernel_row(int left, int center, int right);
		return {16'(right), 16'(center), 16'(left)};
	endfunction

	function automatic logic [KREG_W-1:0] random_row(int lo, int hi);
		return kernel_row(int'($urandom_range(0, hi - lo)) + lo,
			int'($urandom_range(0, hi - lo)) + lo, int'($urandom_range(0, hi - lo)) + lo);
	endfunction

	// full 3x3 sum of products, truncated and clamped; a mirrored window
	// takes rows (middle, bottom, middle) of each stored column
	function automatic pix_t filter_window(col_t left, col_t center, col_t right, bit mirrored);
		col_t              taps [KSIZE];
		longint            acc;
		int                src;
		int                i;
		int                j;
		logic signed [15:0] coef;
		taps[0] = left;
		taps[1] = center;
		taps[2] = right;
		acc = 0;
		for (i = 0; i < KSIZE; i++) begin
			for (j = 0; j < KSIZE; j++) begin
				src = mirrored ? ((i == 1) ? 2 : 1) : i;
				coef = kernel_rows[i][16*j +: 16];
				acc += longint'(taps[j][src]) * longint'(coef);
			end
		end
		if (acc <= 0)
			return '0;
		acc = acc >>> FRAC_BITS;
		return (acc > PIX_MAX) ? pix_t'(PIX_MAX) : pix_t'(acc);
	endfunction

	// advance the filter by one input pixel and queue the results it releases
	function automatic void advance_filter(pix_t px);
		filtered_t run [$];
		int        w;
		int        h;
		int        c;
		int        r;
		pix_t      top;
		pix_t      mid;
		col_t      left;
		bit        last_col;
		bit        last_row;
		w = (cfg_width < 2) ? 2 : ((cfg_width > LINE_MAX) ? LINE_MAX : int'(cfg_width));
		h = (cfg_height < 2) ? 2 : int'(cfg_height);
		c = col_pos;
		r = row_pos;
		top = upper_row[c];
		mid = lower_row[c];
		last_col = (c + 1 >= w);
		last_row = (r + 1 >= h);
		// second row: the row above is reflected from the one below
		if (r == 1)
			top = px;
		upper_row[c] = lower_row[c];
		lower_row[c] = px;
		window[0] = window[1];
		window[1] = window[2];
		window[2][0] = top;
		window[2][1] = mid;
		window[2][2] = px;
		if (r >= 1) begin
			// left border reflects the column to the right
			left = (c == 1) ? window[2] : window[0];
			if (c >= 1) begin
				run.push_back(filtered_t'{filter_window(left, window[1], window[2], 1'b0),
					1'b0, 1'b0});
				if (last_row)
					run.push_back(filtered_t'{filter_window(left, window[1], window[2], 1'b1),
						1'b0, 1'b0});
			end
			// right border reflects the column to the left
			if (last_col) begin
				run.push_back(filtered_t'{filter_window(window[1], window[2], window[1], 1'b0),
					1'b0, 1'b0});
				if (last_row)
					run.push_back(filtered_t'{filter_window(window[1], window[2], window[1],
						1'b1), 1'b0, 1'b1});
			end
			if (run.size() > 0)
				run[run.size() - 1].last_run = 1'b1;
		end
		foreach (run[k])
			queued_outputs.push_back(run[k]);
		if (last_col) begin
			col_pos = '0;
			row_pos = last_row ? '0 : 16'(r + 1);
		end else begin
			col_pos = 12'(c + 1);
		end
	endfunction

	// offer one pixel and hold it until the transfer
	task automatic send_pixel(input pix_t value);
		pixel_in <= value;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (pixel_stall);
		advance_filter(value);
		pixels_sent++;
		if (!steady_sender) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				pixel_valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				burst_left = $urandom_range(0, 24);
			end
		end
	endtask

	// style 0 random, 1 black or white, 2 ramp, 3 all white
	task automatic send_frame(input int count, input int style);
		int   i;
		pix_t value;
		for (i = 0; i < count; i++) begin
			case (style)
				0: value = pix_t'($urandom);
				1: value = $urandom_range(0, 1) ? pix_t'(PIX_MAX) : '0;
				2: value = pix_t'(i * 37);
				default: value = pix_t'(PIX_MAX);
			endcase
			send_pixel(value);
		end
	endtask

	// drop valid, wait for every queued result, then let the pipeline drain
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		while (queued_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup and access phase; bits above the register width carry noise
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
		int          bits;
		logic [63:0] mask;
		logic [63:0] data;
		case (idx)
			REG_WIDTH:  bits = WREG_W;
			REG_HEIGHT: bits = HREG_W;
			default:    bits = KREG_W;
		endcase
		mask = (64'd1 << bits) - 64'd1;
		data = ({$urandom, $urandom} & ~mask) | (value & mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 3'b000});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_writes++;
		case (idx)
			REG_WIDTH:  cfg_width = data[WREG_W-1:0];
			REG_HEIGHT: cfg_height = data[HREG_W-1:0];
			REG_KTOP:   kernel_rows[0] = data[KREG_W-1:0];
			REG_KMID:   kernel_rows[1] = data[KREG_W-1:0];
			REG_KBOT:   kernel_rows[2] = data[KREG_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_frame(input int w, input int h);
		write_reg(REG_WIDTH, 64'(w));
		write_reg(REG_HEIGHT, 64'(h));
	endtask

	task automatic write_kernel(input logic [KREG_W-1:0] top, input logic [KREG_W-1:0] mid,
			input logic [KREG_W-1:0] bot);
		write_reg(REG_KTOP, 64'(top));
		write_reg(REG_KMID, 64'(mid));
		write_reg(REG_KBOT, 64'(bot));
	endtask

	// identity kernel and 512-wide rows from reset, then a mid-frame shrink
	// that leaves the column and row counters at or past the new bounds
	task automatic test_reset_defaults();
		send_frame(2 * 512 + 10, 0);
		wait_idle();
		set_frame(4, 3);
		send_frame(1, 1);
		wait_idle();
	endtask

	// hand-picked windows: sharpening, saturation both ways, truncation
	task automatic test_directed_windows();
		pix_t corner_mix [9];
		corner_mix = '{8'd0, 8'd255, 8'd0, 8'd255, 8'h55, 8'hAA, 8'd0, 8'd255, 8'h80};
		set_frame(3, 3);
		write_kernel(kernel_row(0, -256, 0), kernel_row(-256, 1280, -256),
			kernel_row(0, -256, 0));
		foreach (corner_mix[i])
			send_pixel(corner_mix[i]);
		wait_idle();
		// smallest frame, largest positive coefficients
		set_frame(2, 2);
		write_kernel(kernel_row(32767, 32767, 32767), kernel_row(32767, 32767, 32767),
			kernel_row(32767, 32767, 32767));
		send_frame(4, 3);
		wait_idle();
		// most negative coefficients
		write_kernel(kernel_row(-32768, -32768, -32768), kernel_row(-32768, -32768, -32768),
			kernel_row(-32768, -32768, -32768));
		send_frame(4, 3);
		wait_idle();
		// tiny fractions, the sum truncates to a small integer
		write_kernel(kernel_row(1, 1, 1), kernel_row(1, 1, 1), kernel_row(1, 1, 1));
		send_frame(4, 3);
		wait_idle();
	endtask

	// sizes below the minimum, the widest row, the tallest frame cut short
	task automatic test_size_limits();
		set_frame(0, 1);
		write_kernel(kernel_row(16, 32, 16), kernel_row(32, 64, 32), kernel_row(16, 32, 16));
		send_frame(4, 0);
		wait_idle();
		set_frame(1, 0);
		send_frame(4, 2);
		wait_idle();
		// all width bits set, clamps to the line store depth
		set_frame(13'h1FFF, 2);
		write_kernel(random_row(-128, 384), random_row(-128, 384), random_row(-128, 384));
		send_frame(2 * LINE_MAX, 0);
		wait_idle();
		// tallest frame, height cut below the current row halfway through
		set_frame(2, 16'hFFFF);
		send_frame(6, 0);
		wait_idle();
		write_reg(REG_HEIGHT, 64'd2);
		send_frame(2, 0);
		wait_idle();
	endtask

	// receiver holds off while the sender keeps offering, so the input backs up
	task automatic test_output_holdoff();
		set_frame(6, 5);
		write_kernel(kernel_row(16, 32, 16), kernel_row(32, 64, 32), kernel_row(16, 32, 16));
		steady_sender = 1'b1;
		hold_request = HOLDOFF_CYCLES;
		send_frame(30, 0);
		steady_sender = 1'b0;
		// sender pauses until every result is back
		wait_idle();
	endtask

	// random frame sizes and kernels, sometimes frames back to back
	task automatic test_random_frames();
		int sent;
		int w;
		int h;
		int style;
		bit keep;
		sent = 0;
		w = 2;
		h = 2;
		while (sent < RANDOM_PIXELS) begin
			keep = (sent > 0) && ($urandom_range(0, 2) == 0);
			if (!keep) begin
				wait_idle();
				w = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(2, 10);
				h = $urandom_range(2, 6);
				set_frame(w, h);
				case ($urandom_range(0, 3))
					0: write_kernel(kernel_row(16, 32, 16), kernel_row(32, 64, 32),
						kernel_row(16, 32, 16));
					1: write_kernel(random_row(-128, 384), random_row(-128, 384),
						random_row(-128, 384));
					2: write_kernel(random_row(-300, 0), random_row(0, 1800),
						random_row(-300, 0));
					default: write_kernel(random_row(-32768, 32767), random_row(-32768, 32767),
						random_row(-32768, 32767));
				endcase
			end
			steady_sender = ($urandom_range(0, 3) == 0);
			style = $urandom_range(0, 5);
			send_frame(w * h, (style < 4) ? 0 : style - 3);
			sent += w * h;
		end
		steady_sender = 1'b0;
		wait_idle();
	endtask

	// receiver: random stall patterns, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
				stall_pattern = 8'($urandom);
			end
			mode_left--;
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= ($urandom_range(0, 9) < 7);
				default: begin
					result_stall <= stall_pattern[0];
					stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
				end
			endcase
		end
	end

	// result checker: each transfer against the oldest queued result
	always @(posedge clk) begin : check_result
		filtered_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (queued_outputs.size() == 0) begin
				$display("%0t ns: result with none queued, pixel_out %0d last_of_run %0b end_of_frame %0b",
					$time, pixel_out, last_of_run, end_of_frame);
				errors++;
			end else begin
				want = queued_outputs.pop_front();
				results_checked++;
				if (want.frame_end)
					frames_checked++;
				if (pixel_out !== want.value) begin
					$display("%0t ns: pixel_out expected %0d, got %0d", $time, want.value, pixel_out);
					errors++;
				end
				if (last_of_run !== want.last_run) begin
					$display("%0t ns: last_of_run expected %0b, got %0b", $time, want.last_run,
						last_of_run);
					errors++;
				end
				if (end_of_frame !== want.frame_end) begin
					$display("%0t ns: end_of_frame expected %0b, got %0b", $time, want.frame_end,
						end_of_frame);
					errors++;
				end
			end
		end
	end

	// watchdog: counts clocks with no transfer on any port
	always @(posedge clk) begin
		if (!arst_n || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)
				|| (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t ns: no transfer for %0d cycles, %0d results still queued", $time,
				QUIET_LIMIT, queued_outputs.size());
			$display("conv3x3_reflect_clamp test failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pixel_valid = 1'b0;
		pixel_in = '0;
		result_stall = 1'b0;
		burst_left = 0;
		steady_sender = 1'b0;
		hold_request = 0;
		hold_left = 0;
		stall_mode = 0;
		mode_left = 0;
		stall_pattern = '0;
		errors = 0;
		pixels_sent = 0;
		results_checked = 0;
		frames_checked = 0;
		reg_writes = 0;
		quiet_cycles = 0;
		// predictor state after reset
		cfg_width = WIDTH_RST;
		cfg_height = HEIGHT_RST;
		kernel_rows[0] = '0;
		kernel_rows[1] = KMID_RST;
		kernel_rows[2] = '0;
		foreach (upper_row[i]) begin
			upper_row[i] = '0;
			lower_row[i] = '0;
		end
		foreach (window[i])
			window[i] = '0;
		col_pos = '0;
		row_pos = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_windows();
		test_size_limits();
		test_output_holdoff();
		test_random_frames();

		if (queued_outputs.size() != 0) begin
			$display("%0t ns: %0d results never arrived", $time, queued_outputs.size());
			errors++;
		end
		$display("sent %0d pixels with %0d register writes; checked %0d results over %0d frame ends",
			pixels_sent, reg_writes, results_checked, frames_checked);
		$display("covered border reflection, clamping, mid-frame resizing, full-width rows and output hold-off");
		if (errors == 0)
			$display("conv3x3_reflect_clamp test passed");
		else
			$display("conv3x3_reflect_clamp test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/c3r_pkg.sv
hw/rtl/c3r_linebuf.sv
hw/rtl/c3r_tap_cell.sv
hw/rtl/conv3x3_reflect_clamp.sv
hw/rtl/c3r_checker.sv
test/testbench.sv
